/* sv/pcfwrl_pkg.sv */
// ----------------------------------------------------------------------------
// pcfwrl_pkg
// shared types, codes and constants of the per-client rate limiter
// ----------------------------------------------------------------------------
`default_nettype none

package pcfwrl_pkg;

    localparam int CLIENT_ENTRIES_DEF = 256;

    localparam int KEY_W   = 64;
    localparam int TIME_W  = 48;
    localparam int SEC_W   = 20;
    localparam int MIN_W   = 26;
    localparam int CONN_W  = 16;
    localparam int CCNT_W  = 9;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 32;

    localparam logic [TIME_W-1:0] WIN_SECOND_MS = TIME_W'(1000);
    localparam logic [TIME_W-1:0] WIN_MINUTE_MS = TIME_W'(60000);
    localparam logic [TIME_W-1:0] IDLE_MS       = TIME_W'(600000);

    localparam logic [SEC_W-1:0]  MAX_SEC  = '1;
    localparam logic [MIN_W-1:0]  MAX_MIN  = '1;
    localparam logic [CONN_W-1:0] CONN_SAT = '1;

    localparam logic [SEC_W-1:0]  LIMIT_SEC_RST  = SEC_W'(100);
    localparam logic [MIN_W-1:0]  LIMIT_MIN_RST  = MIN_W'(1000);
    localparam logic [CONN_W-1:0] LIMIT_CONN_RST = CONN_W'(1000);

    typedef enum logic [2:0] {
        KIND_QUERY = 3'd0,
        KIND_CHECK = 3'd1,
        KIND_OPEN  = 3'd2,
        KIND_CLOSE = 3'd3,
        KIND_SWEEP = 3'd4,
        KIND_CLEAR = 3'd5,
        KIND_STATS = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_RATE      = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_CONN_FULL = 2'd3
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        REG_LIMIT_SEC  = 2'd0,
        REG_LIMIT_MIN  = 2'd1,
        REG_LIMIT_CONN = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FETCH,
        ST_UPDATE,
        ST_SWEEP,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [SEC_W-1:0]  sec_cnt;
        logic [MIN_W-1:0]  min_cnt;
        logic [TIME_W-1:0] sec_start;
        logic [TIME_W-1:0] min_start;
    } entry_t;

    typedef struct packed {
        logic             allowed;
        logic [1:0]       status;
        logic [SEC_W-1:0] second_count;
        logic [MIN_W-1:0] minute_count;
    } verdict_t;

    function automatic logic [TIME_W-1:0] elapsed(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] start
    );
        return now - start;
    endfunction

endpackage

`default_nettype wire

/* sv/pcfwrl_req_if.sv */
// ----------------------------------------------------------------------------
// pcfwrl_req_if
// request channel: kind, client key and time stamp
// ----------------------------------------------------------------------------
`default_nettype none

interface pcfwrl_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] client_key;
    logic [47:0] now_ms;

    modport source (output valid, output kind, output client_key, output now_ms,
                    input ready);
    modport sink   (input valid, input kind, input client_key, input now_ms,
                    output ready);
endinterface

`default_nettype wire

/* sv/pcfwrl_rsp_if.sv */
// ----------------------------------------------------------------------------
// pcfwrl_rsp_if
// response channel: verdict and counts
// ----------------------------------------------------------------------------
`default_nettype none

interface pcfwrl_rsp_if;
    logic        valid;
    logic        ready;
    logic        allowed;
    logic [1:0]  status;
    logic [19:0] second_count;
    logic [25:0] minute_count;
    logic [8:0]  client_count;
    logic [15:0] connection_count;

    modport source (output valid, output allowed, output status, output second_count,
                    output minute_count, output client_count, output connection_count,
                    input ready);
    modport sink   (input valid, input allowed, input status, input second_count,
                    input minute_count, input client_count, input connection_count,
                    output ready);
endinterface

`default_nettype wire

/* sv/pcfwrl_cfg_if.sv */
// ----------------------------------------------------------------------------
// pcfwrl_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
`default_nettype none

interface pcfwrl_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/pcfwrl_ram.sv */
// ----------------------------------------------------------------------------
// pcfwrl_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pcfwrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* sv/per_client_fixed_window_rate_limiter.sv */
// ----------------------------------------------------------------------------
// per_client_fixed_window_rate_limiter
// per-client one-second / one-minute query limiter with connection counting
// ----------------------------------------------------------------------------
// query: exec, then a key scan that reads one key ram entry per cycle, then
//   fetch, update and resp; a full table goes from the scan straight to resp
// sweep: exec, a scan of every entry, then resp; other kinds: exec, then resp
// one word in flight; a finished response may wait while the next is accepted
// reset: table empty (valid flops cleared), counts zero, limits 100/1000/1000
// ram contents are not cleared; entries are only read behind a valid bit
`default_nettype none

module per_client_fixed_window_rate_limiter
    import pcfwrl_pkg::*;
#(
    parameter int CLIENT_ENTRIES = CLIENT_ENTRIES_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    pcfwrl_req_if.sink    req,
    pcfwrl_rsp_if.source  rsp,
    pcfwrl_cfg_if.sink    cfg
);

    localparam int IDX_W = $clog2(CLIENT_ENTRIES);
    localparam int CNT_W = $clog2(CLIENT_ENTRIES + 1);
    localparam logic [CNT_W-1:0] N_ENTRIES = CNT_W'(CLIENT_ENTRIES);

    // control state
    state_t                      state_reg, state_next;
    logic [CLIENT_ENTRIES-1:0]   valid_reg, valid_next;
    logic [CNT_W-1:0]            live_reg, live_next;
    logic [CONN_W-1:0]           conn_reg, conn_next;
    logic [CNT_W-1:0]            scan_reg, scan_next;
    logic                        pend_reg, pend_next;
    logic [IDX_W-1:0]            pidx_reg, pidx_next;
    logic                        hit_reg, hit_next;
    logic                        free_reg, free_next;
    logic [IDX_W-1:0]            hidx_reg, hidx_next;
    logic [IDX_W-1:0]            fidx_reg, fidx_next;
    logic                        ovld_reg, ovld_next;

    // config
    logic [SEC_W-1:0]            lim_sec_reg;
    logic [MIN_W-1:0]            lim_min_reg;
    logic [CONN_W-1:0]           lim_conn_reg;

    // payload
    logic [2:0]                  kind_reg;
    logic [KEY_W-1:0]            key_reg;
    logic [TIME_W-1:0]           now_reg;
    verdict_t                    res_reg, res_next;
    verdict_t                    out_reg, out_next;
    logic [CCNT_W-1:0]           ocli_reg, ocli_next;
    logic [CONN_W-1:0]           ocon_reg, ocon_next;

    // ram ports
    logic                        key_we, ent_we;
    logic [IDX_W-1:0]            raddr, slot;
    logic [KEY_W-1:0]            key_rdata;
    entry_t                      ent_rdata, ent_wdata, ent_cur;

    // update datapath
    logic                        sec_rst, min_rst, refuse;
    logic [SEC_W-1:0]            sec_val;
    logic [MIN_W-1:0]            min_val;

    logic req_fire;
    assign req_fire = req.valid && req.ready;
    assign slot     = hit_reg ? hidx_reg : fidx_reg;

    pcfwrl_ram #(.WIDTH(KEY_W), .DEPTH(CLIENT_ENTRIES)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (slot),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    pcfwrl_ram #(.WIDTH($bits(entry_t)), .DEPTH(CLIENT_ENTRIES)) u_ent_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (slot),
        .wdata (ent_wdata),
        .raddr (raddr),
        .rdata (ent_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                priority if (kind_reg == KIND_QUERY)
                begin
                    state_next = ST_SCAN;
                end
                else if (kind_reg == KIND_SWEEP)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == N_ENTRIES && !pend_reg)
                begin
                    state_next = (hit_reg || free_reg) ? ST_FETCH : ST_RESP;
                end
            end
            ST_FETCH:  state_next = ST_UPDATE;
            ST_UPDATE: state_next = ST_RESP;
            ST_SWEEP:
            begin
                if (scan_reg == N_ENTRIES && !pend_reg)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!ovld_reg || rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        req.ready = (state_reg == ST_IDLE);
        raddr     = (state_reg == ST_FETCH) ? slot : scan_reg[IDX_W-1:0];
        ent_we    = (state_reg == ST_UPDATE);
        key_we    = (state_reg == ST_UPDATE) && !hit_reg;
    end

    // window restart and count update for the chosen entry
    always_comb
    begin
        if (hit_reg)
        begin
            ent_cur = ent_rdata;
        end
        else
        begin
            ent_cur = '{sec_cnt: '0, min_cnt: '0, sec_start: now_reg, min_start: now_reg};
        end
        sec_rst = elapsed(now_reg, ent_cur.sec_start) >= WIN_SECOND_MS;
        min_rst = elapsed(now_reg, ent_cur.min_start) >= WIN_MINUTE_MS;
        sec_val = sec_rst ? '0 : ent_cur.sec_cnt;
        min_val = min_rst ? '0 : ent_cur.min_cnt;
        refuse  = (sec_val >= lim_sec_reg) || (min_val >= lim_min_reg);
        if (!refuse)
        begin
            if (sec_val != MAX_SEC)
            begin
                sec_val = sec_val + SEC_W'(1);
            end
            if (min_val != MAX_MIN)
            begin
                min_val = min_val + MIN_W'(1);
            end
        end
        ent_wdata.sec_cnt   = sec_val;
        ent_wdata.min_cnt   = min_val;
        ent_wdata.sec_start = sec_rst ? now_reg : ent_cur.sec_start;
        ent_wdata.min_start = min_rst ? now_reg : ent_cur.min_start;
    end

    // datapath next values
    always_comb
    begin
        valid_next = valid_reg;
        live_next  = live_reg;
        conn_next  = conn_reg;
        scan_next  = scan_reg;
        pend_next  = 1'b0;
        pidx_next  = pidx_reg;
        hit_next   = hit_reg;
        free_next  = free_reg;
        hidx_next  = hidx_reg;
        fidx_next  = fidx_reg;
        res_next   = res_reg;
        out_next   = out_reg;
        ocli_next  = ocli_reg;
        ocon_next  = ocon_reg;
        ovld_next  = ovld_reg && !rsp.ready;

        unique case (state_reg)
            ST_EXEC:
            begin
                scan_next = '0;
                hit_next  = 1'b0;
                free_next = 1'b0;
                res_next  = '0;
                unique case (kind_reg)
                    KIND_CHECK:
                    begin
                        if (conn_reg < lim_conn_reg)
                        begin
                            res_next.allowed = 1'b1;
                        end
                        else
                        begin
                            res_next.status = STAT_CONN_FULL;
                        end
                    end
                    KIND_OPEN:
                    begin
                        if (conn_reg != CONN_SAT)
                        begin
                            conn_next = conn_reg + CONN_W'(1);
                        end
                    end
                    KIND_CLOSE:
                    begin
                        if (conn_reg != '0)
                        begin
                            conn_next = conn_reg - CONN_W'(1);
                        end
                    end
                    KIND_CLEAR:
                    begin
                        valid_next = '0;
                        live_next  = '0;
                        conn_next  = '0;
                    end
                    default: ;
                endcase
            end
            ST_SCAN, ST_SWEEP:
            begin
                // issue one read a cycle, examine the word read last cycle
                if (scan_reg != N_ENTRIES)
                begin
                    scan_next = scan_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = scan_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (state_reg == ST_SCAN)
                    begin
                        if (valid_reg[pidx_reg])
                        begin
                            if (!hit_reg && key_rdata == key_reg)
                            begin
                                hit_next  = 1'b1;
                                hidx_next = pidx_reg;
                            end
                        end
                        else if (!free_reg)
                        begin
                            free_next = 1'b1;
                            fidx_next = pidx_reg;
                        end
                    end
                    else if (valid_reg[pidx_reg] &&
                             elapsed(now_reg, ent_rdata.min_start) > IDLE_MS)
                    begin
                        valid_next[pidx_reg] = 1'b0;
                        live_next            = live_reg - CNT_W'(1);
                    end
                end
                if (state_reg == ST_SCAN && scan_reg == N_ENTRIES && !pend_reg &&
                    !hit_reg && !free_reg)
                begin
                    res_next.status = STAT_FULL;
                end
            end
            ST_UPDATE:
            begin
                if (!hit_reg)
                begin
                    valid_next[slot] = 1'b1;
                    live_next        = live_reg + CNT_W'(1);
                end
                res_next.allowed      = !refuse;
                res_next.status       = refuse ? STAT_RATE : STAT_OK;
                res_next.second_count = sec_val;
                res_next.minute_count = min_val;
            end
            ST_RESP:
            begin
                if (!ovld_reg || rsp.ready)
                begin
                    out_next  = res_reg;
                    ocli_next = CCNT_W'(live_reg);
                    ocon_next = conn_reg;
                    ovld_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            live_reg     <= '0;
            conn_reg     <= '0;
            scan_reg     <= '0;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            free_reg     <= 1'b0;
            ovld_reg     <= 1'b0;
            lim_sec_reg  <= LIMIT_SEC_RST;
            lim_min_reg  <= LIMIT_MIN_RST;
            lim_conn_reg <= LIMIT_CONN_RST;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            live_reg  <= live_next;
            conn_reg  <= conn_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            hit_reg   <= hit_next;
            free_reg  <= free_next;
            ovld_reg  <= ovld_next;
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    REG_LIMIT_SEC:  lim_sec_reg  <= cfg.data[SEC_W-1:0];
                    REG_LIMIT_MIN:  lim_min_reg  <= cfg.data[MIN_W-1:0];
                    REG_LIMIT_CONN: lim_conn_reg <= cfg.data[CONN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            kind_reg <= req.kind;
            key_reg  <= req.client_key;
            now_reg  <= req.now_ms;
        end
        pidx_reg <= pidx_next;
        hidx_reg <= hidx_next;
        fidx_reg <= fidx_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        ocli_reg <= ocli_next;
        ocon_reg <= ocon_next;
    end

    assign cfg.ready            = 1'b1;
    assign rsp.valid            = ovld_reg;
    assign rsp.allowed          = out_reg.allowed;
    assign rsp.status           = out_reg.status;
    assign rsp.second_count     = out_reg.second_count;
    assign rsp.minute_count     = out_reg.minute_count;
    assign rsp.client_count     = ocli_reg;
    assign rsp.connection_count = ocon_reg;

endmodule

`default_nettype wire

/* sv/pcfwrl_checker.sv */
// ----------------------------------------------------------------------------
// pcfwrl_checker
// port-level checks of the rate limiter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module pcfwrl_checker
    import pcfwrl_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic        allowed,
    input wire logic [1:0]  status,
    input wire logic [19:0] second_count,
    input wire logic [25:0] minute_count
);

    // a pending response holds its word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(allowed))
        else $error("response dropped or changed while stalled");

    // one word at a time: accept closes the request side
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while busy");

    // full table reports nothing counted
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == STAT_FULL |->
            !allowed && second_count == '0 && minute_count == '0)
        else $error("table full response with counts");

    // allowed only with ok status
    a_allowed_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && allowed |-> status == STAT_OK)
        else $error("allowed with error status");

endmodule

bind per_client_fixed_window_rate_limiter pcfwrl_checker u_pcfwrl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .allowed      (rsp.allowed),
    .status       (rsp.status),
    .second_count (rsp.second_count),
    .minute_count (rsp.minute_count)
);

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// checks the per-client rate limiter against a behavioral table model;
// directed words cover limits, windows, full table, connections, sweep and
// clear, then random bursts of every kind with idle gaps on both channels
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import pcfwrl_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES    = 256;
    localparam int QUIET_MAX  = 20000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYC  = ENTRIES + 20;

    typedef struct packed {
        logic [2:0]        kind;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] now;
    } word_t;

    typedef struct packed {
        logic              allowed;
        logic [1:0]        status;
        logic [SEC_W-1:0]  sec;
        logic [MIN_W-1:0]  min;
        logic [CCNT_W-1:0] clients;
        logic [CONN_W-1:0] conns;
    } answer_t;

    logic clk;
    logic rst_n;

    pcfwrl_req_if req ();
    pcfwrl_rsp_if rsp ();
    pcfwrl_cfg_if cfg ();

    per_client_fixed_window_rate_limiter #(.CLIENT_ENTRIES(ENTRIES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    // ------------------------------------------------------------------
    // table model: own copy of limits, entries and counts
    // ------------------------------------------------------------------
    logic [SEC_W-1:0]  lim_sec;
    logic [MIN_W-1:0]  lim_min;
    logic [CONN_W-1:0] lim_conn;
    logic              tbl_valid [ENTRIES];
    logic [KEY_W-1:0]  tbl_key   [ENTRIES];
    logic [SEC_W-1:0]  tbl_sec   [ENTRIES];
    logic [MIN_W-1:0]  tbl_min   [ENTRIES];
    logic [TIME_W-1:0] tbl_sst   [ENTRIES];
    logic [TIME_W-1:0] tbl_mst   [ENTRIES];
    logic [CONN_W-1:0] open_conns;
    int                live;

    answer_t expected_answers [$];
    word_t   pending_words [$];
    int      mismatches;
    int      words_sent;
    int      answers_seen;
    int      refusals;
    int      full_hits;
    int      quiet;
    int      drain_wait;   // set by the stimulus when it holds off for a drain

    function automatic void limiter_reset();
        for (int i = 0; i < ENTRIES; i++)
            tbl_valid[i] = 1'b0;
        live       = 0;
        open_conns = '0;
        lim_sec    = LIMIT_SEC_RST;
        lim_min    = LIMIT_MIN_RST;
        lim_conn   = LIMIT_CONN_RST;
    endfunction

    function automatic answer_t limiter_answer(word_t w);
        answer_t a;
        int slot;
        int free_slot;
        logic [TIME_W-1:0] dt;
        a = '0;
        slot = -1;
        free_slot = -1;
        case (w.kind)
            KIND_QUERY:
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        if (slot < 0 && tbl_key[i] == w.key)
                            slot = i;
                    end
                    else if (free_slot < 0)
                        free_slot = i;
                end
                // new client claims lowest free slot
                if (slot < 0 && free_slot >= 0)
                begin
                    slot = free_slot;
                    tbl_valid[slot] = 1'b1;
                    tbl_key[slot]   = w.key;
                    tbl_sec[slot]   = '0;
                    tbl_min[slot]   = '0;
                    tbl_sst[slot]   = w.now;
                    tbl_mst[slot]   = w.now;
                    live++;
                end
                if (slot < 0)
                    a.status = STAT_FULL;
                else
                begin
                    // elapsed time wraps at 48 bits, backwards time restarts
                    dt = w.now - tbl_sst[slot];
                    if (dt >= WIN_SECOND_MS)
                    begin
                        tbl_sec[slot] = '0;
                        tbl_sst[slot] = w.now;
                    end
                    dt = w.now - tbl_mst[slot];
                    if (dt >= WIN_MINUTE_MS)
                    begin
                        tbl_min[slot] = '0;
                        tbl_mst[slot] = w.now;
                    end
                    if (tbl_sec[slot] >= lim_sec || tbl_min[slot] >= lim_min)
                        a.status = STAT_RATE;
                    else
                    begin
                        if (tbl_sec[slot] != MAX_SEC)
                            tbl_sec[slot]++;
                        if (tbl_min[slot] != MAX_MIN)
                            tbl_min[slot]++;
                        a.allowed = 1'b1;
                    end
                    a.sec = tbl_sec[slot];
                    a.min = tbl_min[slot];
                end
            end
            KIND_CHECK:
            begin
                if (open_conns < lim_conn)
                    a.allowed = 1'b1;
                else
                    a.status = STAT_CONN_FULL;
            end
            KIND_OPEN:
                if (open_conns != CONN_SAT)
                    open_conns++;
            KIND_CLOSE:
                if (open_conns != 0)
                    open_conns--;
            KIND_SWEEP:
                for (int i = 0; i < ENTRIES; i++)
                begin
                    dt = w.now - tbl_mst[i];
                    if (tbl_valid[i] && dt > IDLE_MS)
                    begin
                        tbl_valid[i] = 1'b0;
                        live--;
                    end
                end
            KIND_CLEAR:
            begin
                for (int i = 0; i < ENTRIES; i++)
                    tbl_valid[i] = 1'b0;
                live       = 0;
                open_conns = '0;
            end
            default: ;  // stats and the unused kind change nothing
        endcase
        a.clients = CCNT_W'(live);
        a.conns   = open_conns;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // request driver: pops pending words, random gap before each
    // ------------------------------------------------------------------
    int gap_req;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid      <= 1'b0;
            req.kind       <= '0;
            req.client_key <= '0;
            req.now_ms     <= '0;
            gap_req        <= $urandom_range(0, 19);
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                // model the word at its handshake
                expected_answers.push_back(limiter_answer(
                    word_t'{req.kind, req.client_key, req.now_ms}));
                words_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (gap_req > 0)
                begin
                    req.valid <= 1'b0;
                    gap_req   <= gap_req - 1;
                end
                else if (pending_words.size() > 0 && drain_wait == 0)
                begin
                    word_t w;
                    w = pending_words.pop_front();
                    req.valid      <= 1'b1;
                    req.kind       <= w.kind;
                    req.client_key <= w.key;
                    req.now_ms     <= w.now;
                    // a stretch of back-to-back words every so often
                    gap_req <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // response monitor: random stalls, compare with oldest expectation
    // ------------------------------------------------------------------
    int stall_rsp;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_rsp <= $urandom_range(0, 19);
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                answer_t got;
                answer_t want;
                got = answer_t'{rsp.allowed, rsp.status, rsp.second_count,
                                rsp.minute_count, rsp.client_count,
                                rsp.connection_count};
                answers_seen++;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t unexpected word: %p", $realtime, got);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (want.status == STAT_RATE)
                        refusals++;
                    if (want.status == STAT_FULL)
                        full_hits++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t mismatch: expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
                stall_rsp <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
                rsp.ready <= 1'b0;
            end
            else if (stall_rsp > 0)
            begin
                rsp.ready <= 1'b0;
                stall_rsp <= stall_rsp - 1;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // watchdog on handshake activity
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)
            || (cfg.valid && cfg.ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("watchdog expired");
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_word(kind_t k, logic [KEY_W-1:0] key,
                                     logic [TIME_W-1:0] now);
        pending_words.push_back(word_t'{k, key, now});
    endfunction

    task automatic wait_drained();
        while (pending_words.size() > 0 || req.valid)
            @(posedge clk);
        // hold the sender until every answer is back
        drain_wait = 1;
        while (expected_answers.size() > 0)
            @(posedge clk);
        // then let the block idle before releasing the sender
        repeat (ENTRIES + 10) @(posedge clk);
        drain_wait = 0;
    endtask

    // register write between phases, while idle
    task automatic write_limit(reg_idx_t idx, logic [CDATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_LIMIT_SEC:  lim_sec  = value[SEC_W-1:0];
            REG_LIMIT_MIN:  lim_min  = value[MIN_W-1:0];
            default:        lim_conn = value[CONN_W-1:0];
        endcase
        @(posedge clk);
    endtask

    function automatic logic [KEY_W-1:0] rand_key64();
        return {$urandom(), $urandom()};
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [TIME_W-1:0] clock_ms;
        logic [KEY_W-1:0]  pool [8];
        int                r;
        cfg.valid  = 1'b0;
        cfg.index  = '0;
        cfg.data   = '0;
        mismatches = 0;
        words_sent = 0;
        answers_seen = 0;
        refusals   = 0;
        full_hits  = 0;
        drain_wait = 0;
        limiter_reset();
        @(posedge rst_n);
        @(posedge clk);

        // directed: reset limits, extremes of key and time
        add_word(KIND_QUERY, '0, '0);
        add_word(KIND_QUERY, '1, '1);
        add_word(KIND_QUERY, '1, 48'd0);      // elapsed time wraps to one, windows kept
        add_word(KIND_QUERY, '1, 48'd999);
        add_word(KIND_QUERY, '1, 48'd1000);   // inside the second window restarted at 999
        add_word(KIND_QUERY, '1, 48'd60000);  // past the minute window, both windows restart
        add_word(KIND_CHECK, '0, '0);
        add_word(KIND_CLOSE, '0, '0);         // close at zero floors
        add_word(KIND_OPEN, '0, '0);
        add_word(KIND_STATS, '0, '0);
        add_word(kind_t'(3'd7), '1, '1);      // unused kind acts as stats
        add_word(KIND_SWEEP, '0, 48'd600000); // exactly at idle bound, kept
        add_word(KIND_SWEEP, '0, 48'd660001); // beyond, dropped
        add_word(KIND_CLEAR, '0, '0);
        wait_drained();

        // tight limits: rate refusal on the second counter, then a new second window
        write_limit(REG_LIMIT_SEC, 32'd2);
        write_limit(REG_LIMIT_MIN, 32'd3);
        write_limit(REG_LIMIT_CONN, 32'd0);
        for (int i = 0; i < 4; i++)
            add_word(KIND_QUERY, 64'h55, 48'd10);
        add_word(KIND_QUERY, 64'h55, 48'd1100);
        add_word(KIND_CHECK, '0, '0);         // limit zero refuses
        wait_drained();

        // a zero second limit refuses every query; max limits with maximum connections
        write_limit(REG_LIMIT_SEC, 32'd0);
        add_word(KIND_QUERY, 64'h77, 48'd5);
        wait_drained();
        write_limit(REG_LIMIT_SEC, 32'hFFFFF);
        write_limit(REG_LIMIT_MIN, 32'h3FFFFFF);
        write_limit(REG_LIMIT_CONN, 32'hFFFF);

        // fill the table to reach the full status
        for (int i = 0; i < ENTRIES + 3; i++)
            add_word(KIND_QUERY, 64'h1000 + i, 48'd7);
        add_word(KIND_SWEEP, '0, 48'd7);
        wait_drained();

        // connection check at the widest limit, then empty everything
        add_word(KIND_CHECK, '0, '0);
        wait_drained();
        add_word(KIND_CLEAR, '0, '0);
        wait_drained();

        // random phases under several limit settings
        clock_ms = TIME_W'(($urandom() % 1000) * 1000);
        for (int phase = 0; phase < 5; phase++)
        begin
            write_limit(REG_LIMIT_SEC, $urandom_range(1, 6));
            write_limit(REG_LIMIT_MIN, $urandom_range(2, 30));
            write_limit(REG_LIMIT_CONN, $urandom_range(0, 8));
            for (int k = 0; k < 8; k++)
                pool[k] = rand_key64();
            for (int n = 0; n < 95; n++)
            begin
                r = $urandom_range(0, 99);
                // time mostly moves forward in small steps
                clock_ms = clock_ms + TIME_W'($urandom_range(0, 400));
                if (r < 2)
                    clock_ms = clock_ms + TIME_W'($urandom_range(0, 700000));
                if (r < 60)
                    add_word(KIND_QUERY, pool[$urandom_range(0, 7)], clock_ms);
                else if (r < 65)
                    add_word(KIND_QUERY, rand_key64(),
                             TIME_W'({$urandom(), $urandom()}));
                else if (r < 72)
                    add_word(KIND_CHECK, rand_key64(), clock_ms);
                else if (r < 82)
                    add_word(KIND_OPEN, rand_key64(), clock_ms);
                else if (r < 90)
                    add_word(KIND_CLOSE, rand_key64(), clock_ms);
                else if (r < 94)
                    add_word(KIND_SWEEP, rand_key64(), clock_ms);
                else if (r < 95)
                    add_word(KIND_CLEAR, rand_key64(), clock_ms);
                else
                    add_word(kind_t'($urandom_range(6, 7)), rand_key64(), clock_ms);
            end
            wait_drained();
        end

        // back to reset values
        write_limit(REG_LIMIT_SEC, CDATA_W'(LIMIT_SEC_RST));
        write_limit(REG_LIMIT_MIN, CDATA_W'(LIMIT_MIN_RST));
        write_limit(REG_LIMIT_CONN, CDATA_W'(LIMIT_CONN_RST));
        add_word(KIND_STATS, '0, '0);
        wait_drained();

        $display("covered %0d words, %0d answers, %0d rate refusals, %0d full-table hits",
                 words_sent, answers_seen, refusals, full_hits);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

/* filelist.f */
sv/pcfwrl_pkg.sv
sv/pcfwrl_req_if.sv
sv/pcfwrl_rsp_if.sv
sv/pcfwrl_cfg_if.sv
sv/pcfwrl_ram.sv
sv/per_client_fixed_window_rate_limiter.sv
sv/pcfwrl_checker.sv
verif/tb.sv
